// ===== rtl/ber_oid_pkg.sv =====
// ----------------------------------------------------------------------------
// ber_oid_pkg
// Shared types, constants and digit-count function of the BER object identifier decoder.
// ----------------------------------------------------------------------------
package ber_oid_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_BAD  = 3'd1;
    localparam logic [2:0] ST_BIG  = 3'd2;
    localparam logic [2:0] ST_MANY = 3'd3;
    localparam logic [2:0] ST_LONG = 3'd4;

    localparam logic [7:0]  CONT_PAD     = 8'h80;
    localparam logic [31:0] ARC_STRIDE   = 32'd40;
    localparam logic [31:0] ARC_SPLIT    = 32'd80;
    localparam logic [7:0]  COMP_SAT     = 8'd128;
    localparam logic [8:0]  TEXT_START   = 9'd1;

    typedef struct packed {
        logic        first;
        logic        has_value;
        logic        has_last;
        logic [1:0]  head_arc;
        logic [31:0] value;
        logic [2:0]  err;
    } oid_entry_t;

    function automatic logic [3:0] digit_count(input logic [31:0] v);
        logic [3:0] d;
        if (v < 32'd10000)
        begin
            if (v < 32'd100)
                d = (v < 32'd10) ? 4'd1 : 4'd2;
            else
                d = (v < 32'd1000) ? 4'd3 : 4'd4;
        end
        else if (v < 32'd100000000)
        begin
            if (v < 32'd100000)
                d = 4'd5;
            else if (v < 32'd1000000)
                d = 4'd6;
            else
                d = (v < 32'd10000000) ? 4'd7 : 4'd8;
        end
        else
        begin
            d = (v < 32'd1000000000) ? 4'd9 : 4'd10;
        end
        return d;
    endfunction

endpackage

// ===== rtl/ber_oid_front.sv =====
// ----------------------------------------------------------------------------
// ber_oid_front
// Accepts content bytes, assembles base-128 values, tracks errors and pushes
// completed values and end-of-identifier words into the queue.
// ----------------------------------------------------------------------------
module ber_oid_front #(
    parameter int MAX_CONTENT_BYTES = 1024
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [7:0]              content_byte,
    input  logic                    last_byte,
    input  logic                    full,
    output logic                    push,
    output ber_oid_pkg::oid_entry_t push_entry
);
    import ber_oid_pkg::*;

    localparam int BCW = $clog2(MAX_CONTENT_BYTES + 1);
    localparam logic [BCW-1:0] BC_MAX = BCW'(MAX_CONTENT_BYTES);

    logic [31:0]    acc_reg, acc_next;
    logic           inside_reg, inside_next;
    logic           first_reg, first_next;
    logic [BCW-1:0] bc_reg, bc_next;
    logic [2:0]     err_reg, err_next;

    logic        fire;
    logic        val_done;
    logic [31:0] done_value;
    logic [31:0] shifted;
    logic [1:0]  arc_x;
    logic [31:0] arc_y;

    function automatic logic [2:0] err_final();
        logic [2:0] e;
        e = err_reg;
        if (bc_reg < BC_MAX && bc_reg + 1'b1 == BC_MAX)
            e = ST_BAD;
        if (e == ST_OK)
        begin
            if (!inside_reg)
            begin
                if (content_byte[7])
                    e = ST_BAD;
            end
            else if (acc_reg[31:25] != 7'd0)
            begin
                e = ST_BIG;
            end
            else if (content_byte[7])
            begin
                e = ST_BAD;
            end
        end
        return e;
    endfunction

    assign in_ready = !full;
    assign fire     = in_valid && !full;
    assign shifted  = {acc_reg[24:0], content_byte[6:0]};

    always_comb
    begin
        acc_next    = acc_reg;
        inside_next = inside_reg;
        first_next  = first_reg;
        bc_next     = bc_reg;
        err_next    = err_reg;
        val_done    = 1'b0;
        done_value  = {24'd0, content_byte};

        if (bc_reg < BC_MAX)
        begin
            bc_next = bc_reg + 1'b1;
            if (bc_next == BC_MAX)
                err_next = ST_BAD;
        end

        if (err_next == ST_OK)
        begin
            if (!inside_reg)
            begin
                if (!content_byte[7])
                begin
                    val_done = 1'b1;
                end
                else if (content_byte == CONT_PAD)
                begin
                    err_next = ST_BAD;
                end
                else
                begin
                    acc_next    = {25'd0, content_byte[6:0]};
                    inside_next = 1'b1;
                end
            end
            else if (acc_reg[31:25] != 7'd0)
            begin
                err_next = ST_BIG;
            end
            else
            begin
                acc_next = shifted;
                if (!content_byte[7])
                begin
                    inside_next = 1'b0;
                    val_done    = 1'b1;
                    done_value  = shifted;
                    acc_next    = '0;
                end
            end
        end

        if (last_byte && err_next == ST_OK && inside_next)
            err_next = ST_BAD;

        if (val_done)
            first_next = 1'b0;

        if (last_byte)
        begin
            acc_next    = '0;
            inside_next = 1'b0;
            first_next  = 1'b1;
            bc_next     = '0;
            err_next    = ST_OK;
        end
    end

    // split the first value into the first two arcs
    always_comb
    begin
        if (done_value < ARC_SPLIT)
        begin
            if (done_value < ARC_STRIDE)
            begin
                arc_x = 2'd0;
                arc_y = done_value;
            end
            else
            begin
                arc_x = 2'd1;
                arc_y = done_value - ARC_STRIDE;
            end
        end
        else
        begin
            arc_x = 2'd2;
            arc_y = done_value - ARC_SPLIT;
        end
    end

    always_comb
    begin
        push_entry.first     = val_done && first_reg;
        push_entry.has_value = val_done;
        push_entry.has_last  = last_byte;
        push_entry.head_arc  = arc_x;
        push_entry.value     = first_reg ? arc_y : done_value;
        push_entry.err       = err_next;
        if (last_byte)
            push_entry.err = (err_reg == ST_OK && bc_reg < BC_MAX
                              && bc_reg + 1'b1 == BC_MAX) ? ST_BAD : err_final();
    end

    assign push = fire && (val_done || last_byte);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= '0;
            inside_reg <= 1'b0;
            first_reg  <= 1'b1;
            bc_reg     <= '0;
            err_reg    <= ST_OK;
        end
        else if (fire)
        begin
            acc_reg    <= acc_next;
            inside_reg <= inside_next;
            first_reg  <= first_next;
            bc_reg     <= bc_next;
            err_reg    <= err_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        fire && last_byte |=> first_reg && !inside_reg && bc_reg == '0 && err_reg == ST_OK)
        else $error("front state not cleared after last byte");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push while queue full");
`endif

endmodule

// ===== rtl/ber_oid_queue.sv =====
// ----------------------------------------------------------------------------
// ber_oid_queue
// Short first-in first-out queue of decoded words between front and back.
// ----------------------------------------------------------------------------
module ber_oid_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  ber_oid_pkg::oid_entry_t push_entry,
    input  logic                    pop,
    output ber_oid_pkg::oid_entry_t head,
    output logic                    empty,
    output logic                    full
);
    import ber_oid_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

    oid_entry_t    slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_pop;

    assign empty  = (count_reg == '0);
    assign full   = (count_reg == CNT_FULL);
    assign head   = slot_reg[rd_ptr_reg];
    assign do_pop = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count out of range");
`endif

endmodule

// ===== rtl/ber_oid_back.sv =====
// ----------------------------------------------------------------------------
// ber_oid_back
// Expands queued words into component and status results, keeps the
// component count and text length, and holds the output register.
// ----------------------------------------------------------------------------
module ber_oid_back #(
    parameter int MAX_COMPONENTS = 128
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ber_oid_pkg::oid_entry_t head,
    input  logic                    empty,
    output logic                    pop,
    input  logic [8:0]              string_buffer_size,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    result_kind,
    output logic [6:0]              component_index,
    output logic [31:0]             component_value,
    output logic [2:0]              status,
    output logic [7:0]              component_total,
    output logic [8:0]              text_length,
    output logic                    final_result
);
    import ber_oid_pkg::*;

    localparam logic [7:0] COMP_LIMIT = 8'(MAX_COMPONENTS);

    logic [7:0] comp_reg, comp_next;
    logic [8:0] len_reg, len_next;
    logic       x_done_reg, x_done_next;
    logic       v_done_reg, v_done_next;
    logic       out_valid_reg, out_valid_next;

    logic        kind_reg, kind_next;
    logic [6:0]  index_reg, index_next;
    logic [31:0] value_reg, value_next;
    logic [2:0]  status_reg, status_next;
    logic [7:0]  total_reg, total_next;
    logic [8:0]  tlen_reg, tlen_next;
    logic        final_reg, final_next;

    logic       slot_free, step, emit;
    logic       do_x, do_v, do_s, last_op;
    logic [9:0] len_sum;
    logic [8:0] len_sat;
    logic [7:0] comp_inc;
    logic [2:0] end_status;

    assign slot_free = !out_valid_reg || out_ready;
    assign step      = !empty && slot_free;
    assign do_x      = head.first && !x_done_reg;
    assign do_v      = !do_x && head.has_value && !v_done_reg;
    assign do_s      = !do_x && !do_v;
    assign last_op   = do_s || (do_v && !head.has_last);

    assign len_sum  = {1'b0, len_reg} + 10'd1 + {6'd0, digit_count(head.value)};
    assign len_sat  = len_sum[9] ? 9'h1ff : len_sum[8:0];
    assign comp_inc = (comp_reg < COMP_SAT) ? comp_reg + 1'b1 : comp_reg;

    always_comb
    begin
        if (head.err != ST_OK)
            end_status = head.err;
        else if (comp_reg >= COMP_LIMIT)
            end_status = ST_MANY;
        else if (len_reg >= string_buffer_size)
            end_status = ST_LONG;
        else
            end_status = ST_OK;
    end

    always_comb
    begin
        comp_next   = comp_reg;
        len_next    = len_reg;
        x_done_next = x_done_reg;
        v_done_next = v_done_reg;
        pop         = 1'b0;
        emit        = 1'b0;
        kind_next   = kind_reg;
        index_next  = index_reg;
        value_next  = value_reg;
        status_next = status_reg;
        total_next  = total_reg;
        tlen_next   = tlen_reg;
        final_next  = final_reg;

        if (step)
        begin
            if (do_x)
            begin
                comp_next   = 8'd1;
                x_done_next = 1'b1;
                emit        = 1'b1;
                kind_next   = 1'b0;
                index_next  = 7'd0;
                value_next  = {30'd0, head.head_arc};
                status_next = ST_OK;
                total_next  = 8'd1;
                tlen_next   = len_reg;
                final_next  = 1'b0;
            end
            else if (do_v)
            begin
                comp_next   = comp_inc;
                len_next    = len_sat;
                v_done_next = 1'b1;
                emit        = (comp_reg < COMP_LIMIT);
                kind_next   = 1'b0;
                index_next  = comp_reg[6:0];
                value_next  = head.value;
                status_next = ST_OK;
                total_next  = comp_inc;
                tlen_next   = len_sat;
                final_next  = 1'b0;
            end
            else
            begin
                comp_next   = '0;
                len_next    = TEXT_START;
                emit        = 1'b1;
                kind_next   = 1'b1;
                index_next  = 7'd0;
                value_next  = '0;
                status_next = end_status;
                total_next  = comp_reg;
                tlen_next   = len_reg;
                final_next  = 1'b1;
            end

            if (last_op)
            begin
                x_done_next = 1'b0;
                v_done_next = 1'b0;
                pop         = 1'b1;
            end
        end

        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comp_reg      <= '0;
            len_reg       <= TEXT_START;
            x_done_reg    <= 1'b0;
            v_done_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            comp_reg      <= comp_next;
            len_reg       <= len_next;
            x_done_reg    <= x_done_next;
            v_done_reg    <= v_done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg   <= kind_next;
            index_reg  <= index_next;
            value_reg  <= value_next;
            status_reg <= status_next;
            total_reg  <= total_next;
            tlen_reg   <= tlen_next;
            final_reg  <= final_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign result_kind     = kind_reg;
    assign component_index = index_reg;
    assign component_value = value_reg;
    assign status          = status_reg;
    assign component_total = total_reg;
    assign text_length     = tlen_reg;
    assign final_result    = final_reg;

`ifndef NO_ASSERTIONS
    a_status_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (kind_reg == final_reg))
        else $error("status result and final flag disagree");
    a_clear_after_status: assert property (@(posedge clk) disable iff (!rst_n)
        step && do_s |=> comp_reg == '0 && len_reg == TEXT_START && !x_done_reg && !v_done_reg)
        else $error("counters not cleared after status");
`endif

endmodule

// ===== rtl/ber_object_identifier_decoder_core.sv =====
// ----------------------------------------------------------------------------
// ber_object_identifier_decoder_core
// Streaming decoder of BER OBJECT IDENTIFIER content bytes into components,
// count, dotted text length and a final status.
// ----------------------------------------------------------------------------
// Path: the byte that causes a result is queued, then the result is registered.
// Throughput: one byte per cycle while the queue is not full; the back end takes
//   one step per result and per component past the limit, so a run of bytes
//   causing two or three results fills the 4-entry queue and holds input back.
// Reset: string_buffer_size returns to 128, all decode state is cleared at
//   once, no clearing pass.
module ber_object_identifier_decoder_core #(
    parameter int MAX_CONTENT_BYTES = 1024,
    parameter int MAX_COMPONENTS    = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  string_buffer_size,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  content_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        result_kind,
    output logic [6:0]  component_index,
    output logic [31:0] component_value,
    output logic [2:0]  status,
    output logic [7:0]  component_total,
    output logic [8:0]  text_length,
    output logic        final_result
);
    import ber_oid_pkg::*;

    logic [8:0] buf_size_reg;
    logic       push, pop, empty, full;
    oid_entry_t push_entry;
    oid_entry_t head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            buf_size_reg <= 9'd128;
        else if (cfg_valid)
            buf_size_reg <= string_buffer_size;
    end

    ber_oid_front #(
        .MAX_CONTENT_BYTES (MAX_CONTENT_BYTES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .content_byte (content_byte),
        .last_byte    (last_byte),
        .full         (full),
        .push         (push),
        .push_entry   (push_entry)
    );

    ber_oid_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (empty),
        .full       (full)
    );

    ber_oid_back #(
        .MAX_COMPONENTS (MAX_COMPONENTS)
    ) u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .head               (head),
        .empty              (empty),
        .pop                (pop),
        .string_buffer_size (buf_size_reg),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .result_kind        (result_kind),
        .component_index    (component_index),
        .component_value    (component_value),
        .status             (status),
        .component_total    (component_total),
        .text_length        (text_length),
        .final_result       (final_result)
    );

endmodule
